// File: sv/mbd_pkg.sv
// Package for the Morse button decoder: widths, register indexes and the
// code-tree character table. No dependencies.
`default_nettype none
package mbd_pkg;

   localparam int CountWidth  = 8;
   localparam int ThreshWidth = 8;
   localparam int CodeWidth   = 5;
   localparam int CharWidth   = 8;
   localparam int CsrIdxWidth = 1;
   localparam int CmpWidth    = (CountWidth > ThreshWidth) ? CountWidth : ThreshWidth;

   typedef logic [CountWidth-1:0]  count_type;
   typedef logic [ThreshWidth-1:0] thresh_type;
   typedef logic [CodeWidth-1:0]   code_type;
   typedef logic [CharWidth-1:0]   char_type;
   typedef logic [CsrIdxWidth-1:0] csr_idx_type;

   localparam csr_idx_type CSR_DASH_TICKS = csr_idx_type'(0);
   localparam csr_idx_type CSR_GAP_TICKS  = csr_idx_type'(1);

   localparam thresh_type DashTicksReset = thresh_type'(60);
   localparam thresh_type GapTicksReset  = thresh_type'(60);
   localparam code_type   CodeMarker     = code_type'(1);
   localparam char_type   OverflowChar   = char_type'(33);

   function automatic char_type morse_lookup(input code_type code);
      char_type ch;
      unique case (code)
         5'd2:    ch = "t";
         5'd3:    ch = "e";
         5'd4:    ch = "m";
         5'd5:    ch = "n";
         5'd6:    ch = "a";
         5'd7:    ch = "i";
         5'd8:    ch = "o";
         5'd9:    ch = "g";
         5'd10:   ch = "k";
         5'd11:   ch = "d";
         5'd12:   ch = "w";
         5'd13:   ch = "r";
         5'd14:   ch = "u";
         5'd15:   ch = "s";
         5'd18:   ch = "q";
         5'd19:   ch = "z";
         5'd20:   ch = "y";
         5'd21:   ch = "c";
         5'd22:   ch = "x";
         5'd23:   ch = "b";
         5'd24:   ch = "j";
         5'd25:   ch = "p";
         5'd26:   ch = "!";
         5'd27:   ch = "l";
         5'd28:   ch = "!";
         5'd29:   ch = "f";
         5'd30:   ch = "v";
         5'd31:   ch = "h";
         default: ch = '0;
      endcase
      return ch;
   endfunction

endpackage
`default_nettype wire

// File: sv/mbd_channels.sv
// Valid/ready channel interfaces for the Morse button decoder.
// Depends on mbd_pkg.
`default_nettype none
interface mbd_req_if;
   logic valid;
   logic ready;
   logic button_level;
   modport source (output valid, output button_level, input ready);
   modport sink (input valid, input button_level, output ready);
endinterface

interface mbd_rsp_if;
   import mbd_pkg::*;
   logic     valid;
   logic     ready;
   logic     led_on;
   logic     char_valid;
   char_type char_code;
   logic     overflow;
   modport source (output valid, output led_on, output char_valid, output char_code,
                   output overflow, input ready);
   modport sink (input valid, input led_on, input char_valid, input char_code,
                 input overflow, output ready);
endinterface
`default_nettype wire

// File: sv/morse_button_decoder_core.sv
// Morse button decoder top level: counters, code register, table lookup, result register.
// Depends on mbd_pkg and the channel interfaces in mbd_channels.sv.
//
//   channel   dir  handshake      payload
//   req_chan  in   valid/ready    button_level
//   rsp_chan  out  valid/ready    led_on, char_valid, char_code, overflow
//   csr_*     in   csr_wr_en      csr_index, csr_wr_data (dash_ticks, gap_ticks)
//
// One transaction per cycle unless rsp_chan stalls; each tick's result appears in
// the result register the cycle after it is accepted. The result register is the
// only buffer: req_chan is ready while it is empty or being drained. Synchronous
// active-high reset restores the thresholds to 60 and the decoder state to idle.
`default_nettype none
module morse_button_decoder_core (
   input  wire                        clock,
   input  wire                        reset,
   mbd_req_if.sink                    req_chan,
   mbd_rsp_if.source                  rsp_chan,
   input  wire                        csr_wr_en,
   input  wire mbd_pkg::csr_idx_type  csr_index,
   input  wire mbd_pkg::thresh_type   csr_wr_data
);
   import mbd_pkg::*;

   localparam count_type CountMax = '1;

   thresh_type dash_ticks_ff, gap_ticks_ff;
   count_type  press_count_ff, press_count_in;
   count_type  release_count_ff, release_count_in;
   code_type   symbol_code_ff, symbol_code_in;
   logic       too_long_ff, too_long_in;
   logic       led_level_ff, led_level_in;

   logic       rsp_valid_ff;
   logic       led_on_ff, led_on_in;
   logic       char_valid_ff, char_valid_in;
   char_type   char_code_ff, char_code_in;
   logic       overflow_ff, overflow_in;

   logic       accept;
   logic       press_stepped, release_stepped;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept = req_chan.valid && req_chan.ready;

   always_comb begin
      press_count_in   = press_count_ff;
      release_count_in = release_count_ff;
      symbol_code_in   = symbol_code_ff;
      too_long_in      = too_long_ff;
      led_level_in     = led_level_ff;
      press_stepped    = 1'b0;
      release_stepped  = 1'b0;
      char_valid_in    = 1'b0;
      char_code_in     = '0;
      overflow_in      = 1'b0;

      if (req_chan.button_level) begin
         press_count_in = '0;
         if (release_count_ff != CountMax) begin
            release_count_in = release_count_ff + count_type'(1);
            release_stepped  = 1'b1;
         end
         led_level_in = 1'b0;
      end else begin
         release_count_in = '0;
         if (press_count_ff != CountMax) begin
            press_count_in = press_count_ff + count_type'(1);
            press_stepped  = 1'b1;
         end
      end

      if (press_stepped && press_count_in == count_type'(1)) begin
         if (symbol_code_ff[CodeWidth-1]) begin
            too_long_in = 1'b1;
         end
         symbol_code_in = {symbol_code_ff[CodeWidth-2:0], 1'b1};
      end
      if (press_stepped && CmpWidth'(press_count_in) == CmpWidth'(dash_ticks_ff)) begin
         led_level_in   = 1'b1;
         symbol_code_in = symbol_code_in - code_type'(1);
      end

      if (release_stepped && CmpWidth'(release_count_in) == CmpWidth'(gap_ticks_ff)) begin
         led_level_in   = 1'b1;
         char_valid_in  = 1'b1;
         overflow_in    = too_long_in;
         char_code_in   = too_long_in ? OverflowChar : morse_lookup(symbol_code_in);
         symbol_code_in = CodeMarker;
         too_long_in    = 1'b0;
      end
      led_on_in = led_level_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dash_ticks_ff    <= DashTicksReset;
         gap_ticks_ff     <= GapTicksReset;
         press_count_ff   <= '0;
         release_count_ff <= CountMax;
         symbol_code_ff   <= CodeMarker;
         too_long_ff      <= 1'b0;
         led_level_ff     <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_DASH_TICKS: dash_ticks_ff <= csr_wr_data;
               CSR_GAP_TICKS:  gap_ticks_ff  <= csr_wr_data;
               default: ;
            endcase
         end
         if (accept) begin
            press_count_ff   <= press_count_in;
            release_count_ff <= release_count_in;
            symbol_code_ff   <= symbol_code_in;
            too_long_ff      <= too_long_in;
            led_level_ff     <= led_level_in;
            rsp_valid_ff     <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         led_on_ff     <= led_on_in;
         char_valid_ff <= char_valid_in;
         char_code_ff  <= char_code_in;
         overflow_ff   <= overflow_in;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.led_on     = led_on_ff;
   assign rsp_chan.char_valid = char_valid_ff;
   assign rsp_chan.char_code  = char_code_ff;
   assign rsp_chan.overflow   = overflow_ff;

endmodule
`default_nettype wire

// File: tb/sv/mbd_decode_check.sv
`timescale 1ns / 100ps
// Transaction checker for the Morse button decoder: mirrors the CSR writes, predicts
// each tick's result and compares it with the result channel. Depends on mbd_pkg
// and the channel interfaces in mbd_channels.sv.
module mbd_decode_check
   import mbd_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   mbd_req_if          req_mon,
   mbd_rsp_if          rsp_mon,
   input  wire         csr_wr_en,
   input  csr_idx_type csr_index,
   input  thresh_type  csr_wr_data,
   output int          error_count,
   output int          outstanding
);

   typedef struct packed {
      logic     led_on;
      logic     char_valid;
      char_type char_code;
      logic     overflow;
   } decoded_tick_type;

   localparam char_type CodeTree [32] = '{
      8'h00, 8'h00, "t", "e", "m", "n", "a", "i",
      "o", "g", "k", "d", "w", "r", "u", "s",
      8'h00, 8'h00, "q", "z", "y", "c", "x", "b",
      "j", "p", "!", "l", "!", "f", "v", "h"
   };

   thresh_type       dash_thr;
   thresh_type       gap_thr;
   count_type        press_cnt;
   count_type        release_cnt;
   code_type         symbol;
   logic             too_long;
   logic             led;
   decoded_tick_type expected_ticks [$];

   initial error_count = 0;

   function automatic decoded_tick_type decode_tick(input logic released);
      decoded_tick_type res;
      logic             press_step;
      logic             release_step;
      res          = '0;
      press_step   = 1'b0;
      release_step = 1'b0;
      if (released) begin
         press_cnt = '0;
         if (release_cnt != '1) begin
            release_cnt  = release_cnt + count_type'(1);
            release_step = 1'b1;
         end
         led = 1'b0;
      end else begin
         release_cnt = '0;
         if (press_cnt != '1) begin
            press_cnt  = press_cnt + count_type'(1);
            press_step = 1'b1;
         end
      end
      if (press_step && press_cnt == count_type'(1)) begin
         if (symbol[CodeWidth-1]) too_long = 1'b1;
         symbol = {symbol[CodeWidth-2:0], 1'b1};
      end
      // dash: the element's bit turns into 0
      if (press_step && press_cnt == dash_thr) begin
         led    = 1'b1;
         symbol = symbol - code_type'(1);
      end
      if (release_step && release_cnt == gap_thr) begin
         led            = 1'b1;
         res.char_valid = 1'b1;
         res.overflow   = too_long;
         res.char_code  = too_long ? OverflowChar : CodeTree[symbol];
         symbol         = CodeMarker;
         too_long       = 1'b0;
      end
      res.led_on = led;
      return res;
   endfunction

   task automatic check_field(input string field, input int exp_val, input int act_val);
      if (exp_val != act_val) begin
         $error("%s: expected %0d, got %0d", field, exp_val, act_val);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      decoded_tick_type exp_tick;
      if (reset) begin
         dash_thr    = DashTicksReset;
         gap_thr     = GapTicksReset;
         press_cnt   = '0;
         release_cnt = '1;
         symbol      = CodeMarker;
         too_long    = 1'b0;
         led         = 1'b0;
         expected_ticks.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_DASH_TICKS: dash_thr = csr_wr_data;
               CSR_GAP_TICKS:  gap_thr  = csr_wr_data;
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_ticks.size() == 0) begin
               $error("result transaction with no expected result");
               error_count++;
            end else begin
               exp_tick = expected_ticks.pop_front();
               check_field("led_on", int'(exp_tick.led_on), int'(rsp_mon.led_on));
               check_field("char_valid", int'(exp_tick.char_valid),
                           int'(rsp_mon.char_valid));
               check_field("char_code", int'(exp_tick.char_code), int'(rsp_mon.char_code));
               check_field("overflow", int'(exp_tick.overflow), int'(rsp_mon.overflow));
            end
         end
         if (req_mon.valid && req_mon.ready)
            expected_ticks.push_back(decode_tick(req_mon.button_level));
      end
      outstanding <= expected_ticks.size();
   end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// Top of the Morse button decoder testbench: clock, reset, tick stimulus, CSR phases
// and the verdict. Depends on mbd_pkg, mbd_channels.sv, the core, mbd_decode_check.
module tb;
   import mbd_pkg::*;

   localparam int QuietLimit = 4000;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   csr_idx_type csr_index;
   thresh_type  csr_wr_data;
   int          error_count;
   int          outstanding;
   int          quiet_cycles = 0;
   int          idle_pct = 0;
   int          stall_pct = 0;
   int          sent = 0;
   int          dash_cur = 60;
   int          gap_cur = 60;

   mbd_req_if req_if ();
   mbd_rsp_if rsp_if ();

   morse_button_decoder_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   mbd_decode_check decode_check_u (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_if),
      .rsp_mon     (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .error_count (error_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_if.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
          || csr_wr_en) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QuietLimit) begin
         $display("tb: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_tick(input logic level);
      while ($urandom_range(99) < idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.button_level <= level;
      do @(posedge clock); while (!req_if.ready);
      sent++;
   endtask

   task automatic send_run(input logic level, input int ticks);
      for (int i = 0; i < ticks; i++) send_tick(level);
   endtask

   // wait until every transaction sent has its result back
   task automatic drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic set_thresholds(input int dash, input int gap);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_DASH_TICKS;
      csr_wr_data <= thresh_type'(dash);
      @(posedge clock);
      csr_index   <= CSR_GAP_TICKS;
      csr_wr_data <= thresh_type'(gap);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      dash_cur = dash;
      gap_cur  = gap;
   endtask

   // one character: dots and dashes split by short releases, then a closing gap
   task automatic send_symbol();
      int elems;
      int plen;
      elems = ($urandom_range(9) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 4);
      for (int e = 0; e < elems; e++) begin
         if (e > 0) send_run(1'b1, (gap_cur > 1) ? $urandom_range(1, gap_cur - 1) : 1);
         if (dash_cur > 1 && $urandom_range(1) == 0)
            plen = $urandom_range(1, dash_cur - 1);
         else
            plen = $urandom_range(dash_cur, dash_cur + 2);
         send_run(1'b0, plen);
      end
      send_run(1'b1, $urandom_range(gap_cur, gap_cur + 3));
   endtask

   task automatic run_phase(input int dash, input int gap, input int idle, input int stall,
                            input int items);
      int stop_at;
      drain();
      set_thresholds(dash, gap);
      idle_pct  = idle;
      stall_pct = stall;
      stop_at   = sent + items;
      while (sent < stop_at) begin
         if ($urandom_range(9) == 0)
            for (int k = $urandom_range(1, 6); k > 0; k--)
               send_tick(1'($urandom_range(1)));
         else
            send_symbol();
      end
   endtask

   initial begin
      req_if.valid        <= 1'b0;
      req_if.button_level <= 1'b1;
      csr_wr_en           <= 1'b0;
      csr_index           <= CSR_DASH_TICKS;
      csr_wr_data         <= '0;
      reset               <= 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset thresholds, release counter saturated
      send_run(1'b1, 1);
      send_run(1'b0, 1);
      send_run(1'b1, 1);
      // dash on the first press tick, emit on the first release tick
      drain();
      set_thresholds(1, 1);
      send_run(1'b0, 1);
      send_run(1'b1, 1);
      // dot then dash
      drain();
      set_thresholds(2, 2);
      send_run(1'b0, 1);
      send_run(1'b1, 1);
      send_run(1'b0, 2);
      send_run(1'b1, 2);
      // too many elements
      for (int i = 0; i < 6; i++) begin
         send_run(1'b0, 1);
         send_run(1'b1, 1);
      end
      send_run(1'b1, 1);
      // zero thresholds never fire
      drain();
      set_thresholds(0, 0);
      send_run(1'b0, 2);
      send_run(1'b1, 2);
      // top thresholds, press counter runs into saturation
      drain();
      set_thresholds(255, 255);
      send_run(1'b0, 257);
      send_run(1'b1, 2);

      run_phase(3, 4, 0, 0, 24);
      run_phase(1, 1, 82, 0, 24);
      run_phase(5, 2, 0, 82, 24);
      run_phase(2, 6, 29, 29, 24);
      run_phase(4, 3, 0, 0, 24);
      run_phase(1, 5, 82, 0, 24);
      run_phase(6, 1, 0, 82, 24);
      run_phase(3, 3, 29, 29, 24);

      drain();
      repeat (4) @(posedge clock);
      if (error_count == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

endmodule

// File: sim.f
sv/mbd_pkg.sv
sv/mbd_channels.sv
sv/morse_button_decoder_core.sv
tb/sv/mbd_decode_check.sv
tb/sv/tb.sv
